[sv/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

  // Geometry of the managed memory.
  localparam int MIN_BLOCK_LOG2 = 6;
  localparam int NUM_ORDERS     = 11;
  localparam int HEADER_BYTES   = 24;

  localparam int UNIT_W    = NUM_ORDERS - 1;
  localparam int UNITS     = 1 << UNIT_W;
  localparam int ORD_W     = $clog2(NUM_ORDERS);
  localparam int MEM_BYTES = 1 << (MIN_BLOCK_LOG2 + NUM_ORDERS - 1);

  // One block header per unit.
  typedef struct packed {
    logic              live;
    logic              alloc;
    logic [ORD_W-1:0]  order;
    logic              nxt_ok;
    logic              prv_ok;
    logic [UNIT_W-1:0] nxt;
    logic [UNIT_W-1:0] prv;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

endpackage

[sv/bba_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/buddy_block_allocator.sv]
`timescale 1ns / 1ps

// Binary buddy allocator. Each request (mode 0 allocate, mode 1 free) yields one
// result: a status and, on a good allocation, the data address. The block
// headers live in a RAM with a registered read, and a sequencer walks
// each request through read-modify-write steps on it, one request at a time.
// The next request is taken once the last result is in the result register,
// and loading that register waits while a held result sees out_stall. After
// reset a clearing pass writes all 1024 headers, one per cycle, during which
// no request is taken; base_address writes are taken at any time.
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] base_address,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] request_bytes,
  input  logic [31:0] data_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] result_address
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ACAP, S_FCHK, S_MERGE, S_BCHK, S_UL, S_PRV_WR, S_UL_N,
    S_NXT_WR, S_UL_END, S_MERGED, S_SPLIT, S_PUSH, S_PH_RD, S_PH_WR, S_DONE
  } state_t;

  localparam logic [ORD_W-1:0] ORD_TOP = ORD_W'(NUM_ORDERS - 1);

  state_t              state;
  logic [UNIT_W-1:0]   clr_cnt;
  logic [31:0]         base;
  logic [UNIT_W-1:0]   list_heads [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] list_ok;
  logic                is_free;
  logic [UNIT_W-1:0]   u;
  logic [UNIT_W-1:0]   b;
  logic [ORD_W-1:0]    cur;
  logic [ORD_W-1:0]    want;
  hdr_t                hv;
  logic [UNIT_W-1:0]   p_addr;
  logic [ORD_W-1:0]    p_ord;
  logic [UNIT_W-1:0]   ph;
  status_t             st_r;
  logic [31:0]         res_r;

  logic                wr_en;
  logic [UNIT_W-1:0]   wr_addr;
  hdr_t                wr_hdr;
  logic                rd_en;
  logic [UNIT_W-1:0]   rd_addr;
  logic [HDR_W-1:0]    rdata;
  hdr_t                rd_hdr;

  logic [31:0]         need;
  logic                too_large;
  logic [ORD_W-1:0]    want_c;
  logic [ORD_W-1:0]    k_sel;
  logic                k_found;
  logic [31:0]         off;
  logic                off_bad;
  logic [UNIT_W-1:0]   off_unit;
  logic [UNIT_W-1:0]   buddy_c;
  logic [UNIT_W-1:0]   half_c;
  logic [ORD_W-1:0]    clamp_ord;
  logic                accept;

  assign rd_hdr    = hdr_t'(rdata);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // Allocation sizing: smallest fitting order and first non-empty list at or above it.
  always_comb begin
    need      = 32'(request_bytes) + 32'(HEADER_BYTES);
    too_large = need > 32'(MEM_BYTES);
    want_c    = ORD_TOP;
    for (int w = NUM_ORDERS - 2; w >= 0; w--) begin
      if ((32'd1 << (MIN_BLOCK_LOG2 + w)) >= need) begin
        want_c = ORD_W'(w);
      end
    end
    k_sel   = '0;
    k_found = 1'b0;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if (ORD_W'(k) >= want_c && list_ok[k]) begin
        k_sel   = ORD_W'(k);
        k_found = 1'b1;
      end
    end
  end

  // Free address check.
  always_comb begin
    off      = data_address - base - 32'(HEADER_BYTES);
    off_bad  = (off >= 32'(MEM_BYTES)) || (off[MIN_BLOCK_LOG2-1:0] != '0);
    off_unit = off[MIN_BLOCK_LOG2 +: UNIT_W];
  end

  assign buddy_c   = u ^ (UNIT_W'(1) << cur);
  assign half_c    = u + (UNIT_W'(1) << (cur - ORD_W'(1)));
  assign clamp_ord = (rd_hdr.order > ORD_TOP) ? ORD_TOP : rd_hdr.order;

  // Header RAM access for each sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_hdr  = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        if (clr_cnt == '0) begin
          wr_hdr.live  = 1'b1;
          wr_hdr.order = ORD_TOP;
        end
      end
      S_IDLE: begin
        if (accept && !mode && !too_large && k_found) begin
          rd_en   = 1'b1;
          rd_addr = list_heads[k_sel];
        end else if (accept && mode && !off_bad) begin
          rd_en   = 1'b1;
          rd_addr = off_unit;
        end
      end
      S_MERGE: begin
        if (cur < ORD_TOP) begin
          rd_en   = 1'b1;
          rd_addr = buddy_c;
        end
      end
      S_UL: begin
        rd_en   = hv.prv_ok;
        rd_addr = hv.prv;
      end
      S_PRV_WR: begin
        wr_en         = 1'b1;
        wr_addr       = hv.prv;
        wr_hdr        = rd_hdr;
        wr_hdr.nxt_ok = hv.nxt_ok;
        wr_hdr.nxt    = hv.nxt;
      end
      S_UL_N: begin
        rd_en   = hv.nxt_ok;
        rd_addr = hv.nxt;
      end
      S_NXT_WR: begin
        wr_en         = 1'b1;
        wr_addr       = hv.nxt;
        wr_hdr        = rd_hdr;
        wr_hdr.prv_ok = hv.prv_ok;
        wr_hdr.prv    = hv.prv;
      end
      S_MERGED: begin
        wr_en   = 1'b1;
        wr_addr = (b < u) ? u : b;
      end
      S_SPLIT: begin
        if (cur <= want) begin
          wr_en        = 1'b1;
          wr_addr      = u;
          wr_hdr.live  = 1'b1;
          wr_hdr.alloc = 1'b1;
          wr_hdr.order = want;
        end
      end
      S_PUSH: begin
        wr_en         = 1'b1;
        wr_addr       = p_addr;
        wr_hdr.live   = 1'b1;
        wr_hdr.order  = p_ord;
        wr_hdr.nxt_ok = list_ok[p_ord];
        wr_hdr.nxt    = list_heads[p_ord];
      end
      S_PH_RD: begin
        rd_en   = 1'b1;
        rd_addr = ph;
      end
      S_PH_WR: begin
        wr_en         = 1'b1;
        wr_addr       = ph;
        wr_hdr        = rd_hdr;
        wr_hdr.prv_ok = 1'b1;
        wr_hdr.prv    = p_addr;
      end
      default: begin
      end
    endcase
  end

  bba_ram #(
    .WIDTH(HDR_W),
    .DEPTH(UNITS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_hdr),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Sequencer, free lists and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      base      <= '0;
      list_ok   <= {1'b1, {(NUM_ORDERS-1){1'b0}}};
      for (int i = 0; i < NUM_ORDERS; i++) begin
        list_heads[i] <= '0;
      end
      out_valid <= 1'b0;
      is_free   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= base_address;
      end
      // The result register empties when taken, unless a new result loads it.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + UNIT_W'(1);
          if (clr_cnt == UNIT_W'(UNITS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_free <= mode;
            res_r   <= '0;
            if (!mode) begin
              want <= want_c;
              cur  <= k_sel;
              u    <= list_heads[k_sel];
              if (too_large) begin
                st_r  <= ST_TOO_LARGE;
                state <= S_DONE;
              end else if (!k_found) begin
                st_r  <= ST_NO_FREE;
                state <= S_DONE;
              end else begin
                st_r  <= ST_OK;
                state <= S_ACAP;
              end
            end else begin
              u <= off_unit;
              if (off_bad) begin
                st_r  <= ST_BAD_FREE;
                state <= S_DONE;
              end else begin
                st_r  <= ST_OK;
                state <= S_FCHK;
              end
            end
          end
        end
        S_ACAP: begin
          hv    <= rd_hdr;
          state <= S_UL;
        end
        S_FCHK: begin
          if (!rd_hdr.live || !rd_hdr.alloc) begin
            st_r  <= ST_BAD_FREE;
            state <= S_DONE;
          end else begin
            cur   <= clamp_ord;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (cur < ORD_TOP) begin
            b     <= buddy_c;
            state <= S_BCHK;
          end else begin
            p_addr <= u;
            p_ord  <= cur;
            state  <= S_PUSH;
          end
        end
        S_BCHK: begin
          if (!rd_hdr.live || rd_hdr.alloc || rd_hdr.order != cur) begin
            p_addr <= u;
            p_ord  <= cur;
            state  <= S_PUSH;
          end else begin
            hv    <= rd_hdr;
            state <= S_UL;
          end
        end
        // Unlink the block held in hv from list cur.
        S_UL: begin
          if (hv.prv_ok) begin
            state <= S_PRV_WR;
          end else begin
            list_heads[cur] <= hv.nxt;
            list_ok[cur]    <= hv.nxt_ok;
            state           <= S_UL_N;
          end
        end
        S_PRV_WR: begin
          state <= S_UL_N;
        end
        S_UL_N: begin
          state <= hv.nxt_ok ? S_NXT_WR : S_UL_END;
        end
        S_NXT_WR: begin
          state <= S_UL_END;
        end
        S_UL_END: begin
          state <= is_free ? S_MERGED : S_SPLIT;
        end
        S_MERGED: begin
          if (b < u) begin
            u <= b;
          end
          cur   <= cur + ORD_W'(1);
          state <= S_MERGE;
        end
        S_SPLIT: begin
          if (cur > want) begin
            p_addr <= half_c;
            p_ord  <= cur - ORD_W'(1);
            cur    <= cur - ORD_W'(1);
            state  <= S_PUSH;
          end else begin
            res_r <= base + (32'(u) << MIN_BLOCK_LOG2) + 32'(HEADER_BYTES);
            state <= S_DONE;
          end
        end
        // Push p_addr onto the head of list p_ord.
        S_PUSH: begin
          ph                <= list_heads[p_ord];
          list_heads[p_ord] <= p_addr;
          list_ok[p_ord]    <= 1'b1;
          if (list_ok[p_ord]) begin
            state <= S_PH_RD;
          end else begin
            state <= is_free ? S_DONE : S_SPLIT;
          end
        end
        S_PH_RD: begin
          state <= S_PH_WR;
        end
        S_PH_WR: begin
          state <= is_free ? S_DONE : S_SPLIT;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= st_r;
            result_address <= res_r;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Only a good allocation carries an address.
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_address == 32'd0)
    else $error("address on a failed request");

  // The sequencer never reads an entry it is writing in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("header read and write collide");

  // No request is taken during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> in_stall || $past(clr_cnt) == UNIT_W'(UNITS - 1))
    else $error("request taken while clearing");
`endif

endmodule

[tb/sv/tb_buddy_block_allocator.sv]
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] base_address = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [15:0] request_bytes = '0;
  logic [31:0] data_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_address;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  buddy_block_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .base_address(base_address),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .request_bytes(request_bytes), .data_address(data_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_address(result_address)
  );

  always #2 clk = ~clk;

  // Shadow allocator state: free lists and per-unit block headers.
  logic [31:0]       cur_base = '0;
  logic              h_live [UNITS];
  logic              h_alloc[UNITS];
  int                h_order[UNITS];
  logic              h_nok  [UNITS];
  logic              h_pok  [UNITS];
  int                h_nxt  [UNITS];
  int                h_prv  [UNITS];
  int                head   [NUM_ORDERS];
  logic              head_ok[NUM_ORDERS];

  // Byte offsets of blocks that are currently allocated.
  int unsigned       taken_offs[$];

  // Results still owed by the block, oldest first.
  status_t           owed_status[$];
  logic [31:0]       owed_addr[$];

  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int rx_mode = 0;
  int hold_req = 0;

  function automatic void list_push(int u, int o);
    h_pok[u] = 1'b0;
    h_nok[u] = head_ok[o];
    h_nxt[u] = head[o];
    if (head_ok[o]) begin
      h_pok[head[o]] = 1'b1;
      h_prv[head[o]] = u;
    end
    head[o] = u;
    head_ok[o] = 1'b1;
  endfunction

  function automatic void list_unlink(int u, int o);
    if (h_pok[u]) begin
      h_nok[h_prv[u]] = h_nok[u];
      h_nxt[h_prv[u]] = h_nxt[u];
    end else begin
      head_ok[o] = h_nok[u];
      head[o] = h_nxt[u];
    end
    if (h_nok[u]) begin
      h_pok[h_nxt[u]] = h_pok[u];
      h_prv[h_nxt[u]] = h_prv[u];
    end
    h_nok[u] = 1'b0;
    h_pok[u] = 1'b0;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < UNITS; i++) begin
      h_live[i] = 0; h_alloc[i] = 0; h_order[i] = 0;
      h_nok[i] = 0; h_pok[i] = 0; h_nxt[i] = 0; h_prv[i] = 0;
    end
    for (int o = 0; o < NUM_ORDERS; o++) begin
      head[o] = 0;
      head_ok[o] = 0;
    end
    cur_base = '0;
    h_live[0] = 1'b1;
    h_order[0] = NUM_ORDERS - 1;
    list_push(0, NUM_ORDERS - 1);
  endfunction

  // Allocation: smallest fitting order, take a list head, split down.
  function automatic void predict_alloc(logic [15:0] req);
    int unsigned need;
    int want;
    int k;
    int u;
    int half;
    need = req + HEADER_BYTES;
    want = 0;
    if (need > MEM_BYTES) begin
      owed_status.push_back(ST_TOO_LARGE);
      owed_addr.push_back('0);
      return;
    end
    while (want < NUM_ORDERS - 1 && (1 << (MIN_BLOCK_LOG2 + want)) < need) want++;
    k = want;
    while (k < NUM_ORDERS && !head_ok[k]) k++;
    if (k >= NUM_ORDERS) begin
      owed_status.push_back(ST_NO_FREE);
      owed_addr.push_back('0);
      return;
    end
    u = head[k];
    list_unlink(u, k);
    while (k > want) begin
      k--;
      half = (u + (1 << k)) % UNITS;
      h_live[half] = 1'b1;
      h_alloc[half] = 1'b0;
      h_order[half] = k;
      list_push(half, k);
    end
    h_live[u] = 1'b1;
    h_alloc[u] = 1'b1;
    h_order[u] = want;
    taken_offs.push_back(u << MIN_BLOCK_LOG2);
    owed_status.push_back(ST_OK);
    owed_addr.push_back(cur_base + (u << MIN_BLOCK_LOG2) + HEADER_BYTES);
  endfunction

  // Free: validate the header, then merge with free buddies of equal order.
  function automatic void predict_free(logic [31:0] a);
    logic [31:0] off;
    int u;
    int b;
    int cur;
    off = a - cur_base - HEADER_BYTES;
    owed_addr.push_back('0);
    if (off >= MEM_BYTES || off[MIN_BLOCK_LOG2-1:0] != 0) begin
      owed_status.push_back(ST_BAD_FREE);
      return;
    end
    u = off >> MIN_BLOCK_LOG2;
    if (!h_live[u] || !h_alloc[u]) begin
      owed_status.push_back(ST_BAD_FREE);
      return;
    end
    foreach (taken_offs[i]) begin
      if (taken_offs[i] == off) begin
        taken_offs.delete(i);
        break;
      end
    end
    cur = h_order[u];
    if (cur > NUM_ORDERS - 1) cur = NUM_ORDERS - 1;
    h_alloc[u] = 1'b0;
    while (cur < NUM_ORDERS - 1) begin
      b = u ^ (1 << cur);
      if (!h_live[b] || h_alloc[b] || h_order[b] != cur) break;
      list_unlink(b, cur);
      if (b < u) begin
        h_live[u] = 1'b0;
        u = b;
      end else begin
        h_live[b] = 1'b0;
      end
      cur++;
      h_live[u] = 1'b1;
      h_alloc[u] = 1'b0;
      h_order[u] = cur;
    end
    h_order[u] = cur;
    list_push(u, cur);
    owed_status.push_back(ST_OK);
  endfunction

  // Receiver: long hold-offs on demand, otherwise the current stall pattern.
  int hold_cnt = 0;
  logic [15:0] stall_pat = 16'h0;
  int pat_pos = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (pat_pos == 0) stall_pat = 16'($urandom());
          out_stall <= stall_pat[pat_pos];
          pat_pos = (pat_pos + 1) % 16;
        end
      endcase
    end
  end

  // Result checker: outputs are stable at the falling edge before acceptance.
  always @(negedge clk) begin
    status_t     want_st;
    logic [31:0] want_addr;
    if (!rst && out_valid && !out_stall) begin
      if (owed_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d address=%h",
                 $time, status, result_address);
        errors++;
      end else begin
        want_st = owed_status.pop_front();
        want_addr = owed_addr.pop_front();
        if (status !== want_st) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time, want_st, status);
          errors++;
        end
        if (result_address !== want_addr) begin
          $display("%0t: address mismatch expected %h actual %h",
                   $time, want_addr, result_address);
          errors++;
        end
      end
    end
  end

  // Offer one request and hold it until accepted; then maybe leave a gap.
  task automatic send_req(logic m, logic [15:0] b, logic [31:0] a);
    bit took;
    in_valid <= 1'b1;
    mode <= m;
    request_bytes <= b;
    data_address <= a;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (m == MODE_ALLOC) predict_alloc(b);
    else predict_free(a);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic alloc_req(logic [15:0] b);
    send_req(MODE_ALLOC, b, $urandom());
  endtask

  task automatic free_req(logic [31:0] a);
    send_req(MODE_FREE, 16'($urandom()), a);
  endtask

  function automatic logic [31:0] addr_of(int unsigned off);
    return cur_base + off + HEADER_BYTES;
  endfunction

  task automatic sender_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    sender_quiet();
    while (owed_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    bit took;
    wait_drained();
    cfg_valid <= 1'b1;
    base_address <= v;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    cur_base = v;
  endtask

  // Size edges, exhaustion, and every kind of bad free.
  task automatic test_directed();
    int unsigned off;
    alloc_req(16'hFFFF);
    alloc_req(16'(MEM_BYTES - HEADER_BYTES + 1));
    alloc_req(16'(MEM_BYTES - HEADER_BYTES));
    alloc_req(16'd0);
    free_req(addr_of(0));
    free_req(addr_of(0));
    alloc_req(16'd40);
    alloc_req(16'd41);
    alloc_req(16'd0);
    off = taken_offs[1];
    free_req(addr_of(off) + (1 << MIN_BLOCK_LOG2));
    free_req(addr_of(off) + 1);
    free_req(addr_of(off + (1 << MIN_BLOCK_LOG2) * 4));
    free_req(32'h0);
    free_req(32'hFFFF_FFFF);
    free_req(addr_of(MEM_BYTES));
    alloc_req(16'h5555);
    alloc_req(16'h2AAA);
    free_req(addr_of(off));
  endtask

  // Mostly legal alloc/free traffic with some oversized and bogus requests.
  task automatic test_random_mix(int n);
    int r;
    int unsigned off;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 48 || (r < 88 && taken_offs.size() == 0)) begin
        if ($urandom_range(0, 19) == 0) alloc_req(16'($urandom()));
        else alloc_req(16'($urandom_range(0, 3000)));
      end else if (r < 88) begin
        off = taken_offs[$urandom_range(0, taken_offs.size() - 1)];
        free_req(addr_of(off));
      end else if (r < 94 || taken_offs.size() == 0) begin
        free_req($urandom());
      end else begin
        off = taken_offs[$urandom_range(0, taken_offs.size() - 1)];
        free_req(addr_of(off) + ($urandom_range(1, 15) << ($urandom_range(0, 1) * 6)));
      end
    end
  endtask

  // Free everything so all buddies merge back into one top-order block.
  task automatic test_drain();
    int unsigned off;
    while (taken_offs.size() != 0) begin
      off = taken_offs[$urandom_range(0, taken_offs.size() - 1)];
      free_req(addr_of(off));
    end
    alloc_req(16'(MEM_BYTES - HEADER_BYTES));
    free_req(addr_of(0));
  endtask

  // Receiver holds off while the sender keeps offering requests.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 400;
    test_random_mix(60);
    gaps_on = 1'b1;
    wait_drained();
    test_random_mix(40);
  endtask

  // Several base settings, extremes among them, each with random traffic.
  task automatic test_base_sweep();
    logic [31:0] bases[4];
    bases = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0, $urandom()};
    foreach (bases[i]) begin
      write_base(bases[i]);
      rx_mode = i % 3;
      test_random_mix(150);
      wait_drained();
      test_random_mix(150);
      if (i == 1) test_drain();
    end
  endtask

  initial begin
    int guard;
    shadow_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_base(32'h0000_1000);
    rx_mode = 1;
    test_random_mix(120);
    test_backpressure();
    test_base_sweep();
    rx_mode = 2;
    test_drain();
    sender_quiet();
    guard = 0;
    while (owed_status.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (owed_status.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_status.size());
      errors++;
    end
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

endmodule
